FILE: design/wrm_pkg.sv
// shared types, widths and controller/datapath command and status words
package wrm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int MAX_WINDOW  = 65536;
    localparam int COUNT_BITS  = 17;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS;
    localparam int SUM_BITS    = 63;
    localparam int RAD_BITS    = SUM_BITS + 1;
    localparam int ROOT_BITS   = RAD_BITS / 2;
    localparam int ROOT_REM_BITS = ROOT_BITS + 1;
    localparam int RMS_BITS    = 24;
    localparam int STEP_BITS   = 6;
    localparam int DIV_STEPS   = SUM_BITS;
    localparam int ROOT_STEPS  = ROOT_BITS;

    localparam logic [COUNT_BITS-1:0] WINDOW_RESET = COUNT_BITS'(1024);
    localparam logic [COUNT_BITS-1:0] WINDOW_MAX   = COUNT_BITS'(MAX_WINDOW);
    localparam logic [SUM_BITS-1:0]   SUM_MAX      = {SUM_BITS{1'b1}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          end_of_block;
    } in_word_t;

    typedef struct packed {
        logic [RMS_BITS-1:0]   rms_value;
        logic [COUNT_BITS-1:0] samples_in_window;
    } out_word_t;

    typedef struct packed {
        logic load_sample;
        logic square;
        logic accumulate;
        logic div_start;
        logic div_step;
        logic root_start;
        logic root_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic close;
        logic div_last;
        logic root_last;
    } sts_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SQUARE = 7'b0000010,
        ST_ACCUM  = 7'b0000100,
        ST_DIVIDE = 7'b0001000,
        ST_RLOAD  = 7'b0010000,
        ST_ROOT   = 7'b0100000,
        ST_WRITE  = 7'b1000000
    } state_t;

endpackage

FILE: design/wrm_ctrl.sv
// sequencing state machine: accept, square, accumulate, divide, root, write
module wrm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  wrm_pkg::sts_t sts,
    output wrm_pkg::cmd_t cmd
);
    import wrm_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accumulate = 1'b1;
                if (sts.close)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_RLOAD;
                end
            end
            ST_RLOAD:
            begin
                cmd.root_start = 1'b1;
                state_next     = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (sts.root_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: design/wrm_datapath.sv
// squarer, accumulator, restoring divider, digit-by-digit root and output register
module wrm_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  wrm_pkg::in_word_t                  in_word,
    input  logic                               cfg_we,
    input  logic [wrm_pkg::COUNT_BITS-1:0]     cfg_data,
    input  wrm_pkg::cmd_t                      cmd,
    output wrm_pkg::sts_t                      sts,
    output wrm_pkg::out_word_t                 out_word
);
    import wrm_pkg::*;

    logic [COUNT_BITS-1:0]    window_reg;
    logic [SAMPLE_BITS-1:0]   mag_reg;
    logic                     last_reg;
    logic [SQ_BITS-1:0]       sq_reg;
    logic [SUM_BITS-1:0]      sum_reg, sum_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [COUNT_BITS-1:0]    divisor_reg;
    logic [COUNT_BITS-1:0]    drem_reg, drem_next;
    logic [SUM_BITS-1:0]      quo_reg, quo_next;
    logic [STEP_BITS-1:0]     step_reg;
    logic [RAD_BITS-1:0]      rad_reg;
    logic [ROOT_REM_BITS-1:0] rrem_reg, rrem_next;
    logic [ROOT_BITS-1:0]     root_reg, root_next;
    out_word_t                out_reg;

    logic [SAMPLE_BITS-1:0]   mag_in;
    logic [SUM_BITS:0]        sum_add;
    logic [COUNT_BITS-1:0]    eff_window;
    logic [COUNT_BITS:0]      dshift;
    logic [COUNT_BITS:0]      ddiff;
    logic                     dge;
    logic [ROOT_REM_BITS+1:0] rshift;
    logic [ROOT_REM_BITS+1:0] rtrial;
    logic [ROOT_REM_BITS+1:0] rdiff;
    logic                     rge;
    logic [RMS_BITS-1:0]      rms_sat;

    // sign magnitude of the incoming word
    assign mag_in = in_word.sample[SAMPLE_BITS-1]
                  ? (~in_word.sample + SAMPLE_BITS'(1))
                  : in_word.sample;

    // saturating accumulate
    assign sum_add = {1'b0, sum_reg} + (SUM_BITS + 1)'(sq_reg);
    assign sum_next = sum_add[SUM_BITS] ? SUM_MAX : sum_add[SUM_BITS-1:0];
    assign count_next = count_reg + COUNT_BITS'(1);

    always_comb
    begin
        eff_window = window_reg;
        if (window_reg == '0)
        begin
            eff_window = COUNT_BITS'(1);
        end
        else if (window_reg > WINDOW_MAX)
        begin
            eff_window = WINDOW_MAX;
        end
    end

    // restoring divide step
    assign dshift    = {drem_reg, quo_reg[SUM_BITS-1]};
    assign ddiff     = dshift - {1'b0, divisor_reg};
    assign dge       = (dshift >= {1'b0, divisor_reg});
    assign drem_next = dge ? ddiff[COUNT_BITS-1:0] : dshift[COUNT_BITS-1:0];
    assign quo_next  = {quo_reg[SUM_BITS-2:0], dge};

    // square root step, two radicand bits per step
    assign rshift    = {rrem_reg, rad_reg[RAD_BITS-1:RAD_BITS-2]};
    assign rtrial    = {1'b0, root_reg, 2'b01};
    assign rdiff     = rshift - rtrial;
    assign rge       = (rshift >= rtrial);
    assign rrem_next = rge ? rdiff[ROOT_REM_BITS-1:0] : rshift[ROOT_REM_BITS-1:0];
    assign root_next = {root_reg[ROOT_BITS-2:0], rge};

    assign rms_sat = (root_reg[ROOT_BITS-1:RMS_BITS] != '0)
                   ? {RMS_BITS{1'b1}} : root_reg[RMS_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            sum_reg    <= '0;
            count_reg  <= '0;
            step_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= cfg_data;
            end
            if (cmd.accumulate)
            begin
                if (cmd.div_start)
                begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    sum_reg   <= sum_next;
                    count_reg <= count_next;
                end
            end
            if (cmd.div_start || cmd.root_start)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step || cmd.root_step)
            begin
                step_reg <= step_reg + STEP_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            mag_reg  <= mag_in;
            last_reg <= in_word.end_of_block;
        end
        if (cmd.square)
        begin
            sq_reg <= mag_reg * mag_reg;
        end
        if (cmd.div_start)
        begin
            quo_reg     <= sum_next;
            divisor_reg <= count_next;
            drem_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg  <= quo_next;
            drem_reg <= drem_next;
        end
        if (cmd.root_start)
        begin
            rad_reg  <= {1'b0, quo_reg};
            rrem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[RAD_BITS-3:0], 2'b00};
            rrem_reg <= rrem_next;
            root_reg <= root_next;
        end
        if (cmd.out_load)
        begin
            out_reg.rms_value         <= rms_sat;
            out_reg.samples_in_window <= divisor_reg;
        end
    end

    assign sts.close     = last_reg || (count_next >= eff_window);
    assign sts.div_last  = (step_reg == STEP_BITS'(DIV_STEPS - 1));
    assign sts.root_last = (step_reg == STEP_BITS'(ROOT_STEPS - 1));
    assign out_word      = out_reg;

endmodule

FILE: design/windowed_rms_meter.sv
// windowed rms level meter top level: controller, datapath and checks
// a sample that does not close a window passes through the square and accumulate states before the next is accepted
// a closing sample adds 63 divide steps, a root load, 32 root steps and a write
// the result is registered in the write state, once the output is free
// throughput is set by the one-bit-per-cycle divider, the two-bit-per-cycle root and output stalls in the write state
// reset: window length 1024, sum and count cleared, no result pending
module windowed_rms_meter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  wrm_pkg::in_word_t              in_word,
    output logic                           out_valid,
    input  logic                           out_ready,
    output wrm_pkg::out_word_t             out_word,
    input  logic                           cfg_we,
    input  logic [wrm_pkg::COUNT_BITS-1:0] cfg_data
);
    import wrm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    wrm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    wrm_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_word),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_word (out_word)
    );

    // a result never overwrites one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("result overwritten while pending");

    // divider only starts on a closing window
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> sts.close)
        else $error("divide started without window close");

    // no new word taken while the divider runs
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !in_ready)
        else $error("input ready during divide");

    // a delivered result always averages at least one sample
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (out_word.samples_in_window != '0))
        else $error("empty window reported");

endmodule

FILE: tb/rms_window_checker.sv
`timescale 1ns / 100ps
// level checker: watches the ports, predicts each level word and compares
module rms_window_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  wrm_pkg::in_word_t              in_word,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  wrm_pkg::out_word_t             out_word,
    input  logic                           cfg_we,
    input  logic [wrm_pkg::COUNT_BITS-1:0] cfg_data,
    output int                             mismatches,
    output int                             levels_pending,
    output int                             levels_checked
);
    import wrm_pkg::*;

    out_word_t             expected_levels[$];
    logic [SUM_BITS-1:0]   sum_of_squares;
    logic [31:0]           open_count;
    logic [COUNT_BITS-1:0] window_setting;

    function automatic logic [31:0] floor_root(input logic [63:0] radicand);
        logic [63:0] rest;
        logic [63:0] root;
        logic [63:0] probe;
        rest  = radicand;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > rest)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rest >= root + probe)
            begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root[31:0];
    endfunction

    function automatic void fold_sample(input in_word_t word);
        logic [SAMPLE_BITS-1:0] raw;
        logic [SAMPLE_BITS-1:0] mag;
        logic [63:0]            square;
        logic [63:0]            limit;
        logic [31:0]            root;
        out_word_t              level;
        raw    = word.sample;
        mag    = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(~raw + 1'b1) : raw;
        square = 64'(mag) * 64'(mag);
        if (square > 64'(SUM_MAX) - 64'(sum_of_squares))
            sum_of_squares = SUM_MAX;
        else
            sum_of_squares = SUM_BITS'(64'(sum_of_squares) + square);
        if (open_count != 32'hFFFF_FFFF)
            open_count = open_count + 1;

        if (window_setting == '0)
            limit = 64'd1;
        else if (window_setting > WINDOW_MAX)
            limit = 64'(WINDOW_MAX);
        else
            limit = 64'(window_setting);

        if (word.end_of_block || 64'(open_count) >= limit)
        begin
            root = floor_root(64'(sum_of_squares) / 64'(open_count));
            level.rms_value         = ((root >> RMS_BITS) != 0) ? '1 : root[RMS_BITS-1:0];
            level.samples_in_window = open_count[COUNT_BITS-1:0];
            expected_levels.push_back(level);
            sum_of_squares = '0;
            open_count     = '0;
        end
    endfunction

    function automatic void check_level(input out_word_t got);
        out_word_t want;
        if (expected_levels.size() == 0)
        begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
                $display("%0t: level word with none expected: rms %0d count %0d",
                         $realtime, got.rms_value, got.samples_in_window);
        end
        else
        begin
            want = expected_levels.pop_front();
            levels_checked = levels_checked + 1;
            if (got.rms_value !== want.rms_value ||
                got.samples_in_window !== want.samples_in_window)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("%0t: rms expected %0d actual %0d, count expected %0d actual %0d",
                             $realtime, want.rms_value, got.rms_value,
                             want.samples_in_window, got.samples_in_window);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_levels.delete();
            sum_of_squares = '0;
            open_count     = '0;
            window_setting = WINDOW_RESET;
            mismatches     = 0;
            levels_pending = 0;
            levels_checked = 0;
        end
        else
        begin
            if (cfg_we)
                window_setting = cfg_data;
            if (out_valid && out_ready)
                check_level(out_word);
            if (in_valid && in_ready)
                fold_sample(in_word);
            levels_pending = expected_levels.size();
        end
    end

endmodule

FILE: tb/windowed_rms_meter_tb.sv
`timescale 1ns / 100ps
// testbench top: drives samples, window settings and level stalls, and gives the verdict
module windowed_rms_meter_tb;
    import wrm_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_word_t              in_word   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_word_t             out_word;
    logic                  cfg_we    = 1'b0;
    logic [COUNT_BITS-1:0] cfg_data  = '0;

    int                    mismatches;
    int                    levels_pending;
    int                    levels_checked;
    int                    cycle_count   = 0;
    int                    samples_sent  = 0;
    int                    settings_used = 0;
    int                    rx_hold       = 0;
    int                    rx_roll       = 0;
    int                    random_target;
    int                    phase_items;
    int                    eob_odds;
    logic [COUNT_BITS-1:0] next_window;
    bit                    tx_steady     = 1'b0;
    bit                    rx_steady     = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    windowed_rms_meter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    rms_window_checker level_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_word        (in_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_word       (out_word),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .levels_pending (levels_pending),
        .levels_checked (levels_checked)
    );

    // level side stalls
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold = rx_hold - 1;
            out_ready <= 1'b0;
        end
        else if (rx_steady)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 70)
            begin
                out_ready <= 1'b1;
            end
            else if (rx_roll < 95)
            begin
                out_ready <= 1'b0;
                rx_hold = $urandom_range(0, 2);
            end
            else
            begin
                out_ready <= 1'b0;
                rx_hold = $urandom_range(20, 150);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d levels still expected",
                     cycle_count, levels_pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int mag;
        mag = $urandom_range(1, 255);
        case ($urandom_range(0, 9))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return SAMPLE_BITS'(mag);
            3: return SAMPLE_BITS'(-mag);
            4: return '0;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        if (tx_steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{sample: value, end_of_block: last};
        do
            @(posedge clk);
        while (!in_ready);
        samples_sent++;
    endtask

    // hold off until every level is out and the block has settled
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (levels_pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_window(input logic [COUNT_BITS-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window length, closes by end of block
        send_sample(24'sh7FFFFF, 1'b0);
        send_sample(24'sh800000, 1'b0);
        send_sample('0, 1'b0);
        send_sample(-24'sd1, 1'b0);
        send_sample(24'sd1, 1'b1);
        send_sample(24'sh800000, 1'b1);
        send_sample('0, 1'b1);

        // zero length acts as one
        wait_quiet();
        set_window('0);
        send_sample(24'sh7FFFFF, 1'b0);
        send_sample(-24'sd1, 1'b0);
        send_sample('0, 1'b0);

        // shortened while a window is open
        wait_quiet();
        set_window(COUNT_BITS'(3));
        send_sample(24'sd12345, 1'b0);
        send_sample(-24'sd777, 1'b0);
        wait_quiet();
        set_window(COUNT_BITS'(1));
        send_sample(24'sd4096, 1'b0);

        wait_quiet();
        set_window(COUNT_BITS'(2));
        send_sample(24'sd100, 1'b1);
        send_sample(-24'sd100, 1'b0);
        send_sample(24'sd200, 1'b0);

        // register above the maximum, full-scale words closed by end of block
        wait_quiet();
        set_window('1);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (99) send_sample(24'sh800000, 1'b0);
        send_sample(24'sh800000, 1'b1);
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        random_target = samples_sent + 850;
        while (samples_sent < random_target)
        begin
            wait_quiet();
            case ($urandom_range(0, 7))
                0: next_window = '0;
                1: next_window = COUNT_BITS'(1);
                2: next_window = COUNT_BITS'($urandom_range(2, 8));
                3: next_window = COUNT_BITS'($urandom_range(9, 64));
                4: next_window = COUNT_BITS'($urandom_range(65, 400));
                5: next_window = '1;
                6: next_window = COUNT_BITS'($urandom_range(0, 131071));
                default: next_window = COUNT_BITS'($urandom_range(2, 32));
            endcase
            set_window(next_window);
            tx_steady   = ($urandom_range(0, 4) == 0);
            rx_steady   = ($urandom_range(0, 4) == 0);
            phase_items = $urandom_range(20, 150);
            eob_odds    = $urandom_range(3, 40);
            repeat (phase_items)
                send_sample(pick_sample(), $urandom_range(1, eob_odds) == 1);
        end

        in_valid <= 1'b0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        @(posedge clk);
        while (levels_pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("%0d samples sent under %0d window settings, %0d window levels checked",
                 samples_sent, settings_used, levels_checked);
        $display("windows of zero, one, short, long and over-range length, full scale and early closes");
        if (mismatches == 0 && levels_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: windowed_rms_meter.f
design/wrm_pkg.sv
design/wrm_ctrl.sv
design/wrm_datapath.sv
design/windowed_rms_meter.sv
tb/rms_window_checker.sv
tb/windowed_rms_meter_tb.sv
